>>> design/bmt_pkg.sv
// Package for the bitset membership table: map geometry, opcodes and the
// command and result records passed between the front, queue and back.
// No dependencies.
`default_nettype none

package bmt_pkg;

  localparam int MAP_WORDS   = 64;
  localparam int WORD_BITS   = 64;
  localparam int ADDR_W      = 6;
  localparam int BIT_W       = 6;
  localparam int ELEM_W      = 12;
  localparam int COUNT_W     = 13;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_MERGE  = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [ADDR_W-1:0]      addr;
    logic [BIT_W-1:0]       sel;
    logic [WORD_BITS-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic                   found;
    logic [ELEM_W-1:0]      member;
    logic                   member_valid;
    logic                   last;
    logic [COUNT_W-1:0]     member_count;
    logic [ELEM_W-1:0]      highest_member;
  } res_t;

endpackage

`default_nettype wire

>>> design/bitset_membership_table_unit.sv
// A command passes the queue register, then the back end's word read and execute states.
// Insert, query and merge each take the word read, then execute; a list of a word with k
// members adds one member per cycle while the output is not stalled. The back end pops no
// new command before it returns to idle. The map word read-modify-write sets this order.
// Reset clears the map at once through per-word valid flags, so no clearing pass is needed.
// Top level of the bitset membership table; uses bmt_pkg, bmt_front, bmt_queue, bmt_back.
`default_nettype none

module bitset_membership_table_unit import bmt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [ELEM_W-1:0]    element_i,
  input  wire logic [ADDR_W-1:0]    word_index_i,
  input  wire logic [WORD_BITS-1:0] word_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      found_o,
  output logic [ELEM_W-1:0]         member_o,
  output logic                      member_valid_o,
  output logic                      last_o,
  output logic [COUNT_W-1:0]        member_count_o,
  output logic [ELEM_W-1:0]         highest_member_o
);

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, queue_valid;
  res_t res;

  bmt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .element_i    (element_i),
    .word_index_i (word_index_i),
    .word_value_i (word_value_i),
    .q_full_i     (full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  bmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  bmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_cmd_i     (queue_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign found_o          = res.found;
  assign member_o         = res.member;
  assign member_valid_o   = res.member_valid;
  assign last_o           = res.last;
  assign member_count_o   = res.member_count;
  assign highest_member_o = res.highest_member;

endmodule

`default_nettype wire

>>> design/bmt_front.sv
// Front end of the bitset membership table: accepts input transfers and
// turns each into a command with its map word, bit and source mask.
// Depends on bmt_pkg.
`default_nettype none

module bmt_front import bmt_pkg::*; (
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [ELEM_W-1:0]    element_i,
  input  wire logic [ADDR_W-1:0]    word_index_i,
  input  wire logic [WORD_BITS-1:0] word_value_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  op_e op;

  assign op         = op_e'(opcode_i);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.op  = op;
    cmd_o.sel = element_i[BIT_W-1:0];
    unique case (op)
      OP_INSERT: begin
        cmd_o.addr  = element_i[ELEM_W-1:BIT_W];
        cmd_o.value = {{(WORD_BITS-1){1'b0}}, 1'b1} << element_i[BIT_W-1:0];
      end
      OP_QUERY: begin
        cmd_o.addr  = element_i[ELEM_W-1:BIT_W];
        cmd_o.value = '0;
      end
      OP_MERGE: begin
        cmd_o.addr  = word_index_i;
        cmd_o.value = word_value_i;
      end
      OP_LIST: begin
        cmd_o.addr  = word_index_i;
        cmd_o.value = '0;
      end
      default: begin
        cmd_o.addr  = '0;
        cmd_o.value = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/bmt_queue.sv
// Short command queue between the front and the back of the bitset
// membership table. Depends on bmt_pkg.
`default_nettype none

module bmt_queue import bmt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> design/bmt_back.sv
// Back end of the bitset membership table: holds the map memory, the count
// and the highest member, executes queued commands and drives the result
// register. Depends on bmt_pkg.
`default_nettype none

module bmt_back import bmt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_e;

  function automatic logic [BIT_W:0] ones64(input logic [WORD_BITS-1:0] w);
    logic [3:0]     part [8];
    logic [BIT_W:0] sum;
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      part[b] = '0;
      for (int i = 0; i < 8; i++) begin
        part[b] = part[b] + 4'(w[b*8+i]);
      end
    end
    for (int b = 0; b < 8; b++) begin
      sum = sum + (BIT_W+1)'(part[b]);
    end
    return sum;
  endfunction

  function automatic logic [BIT_W-1:0] top64(input logic [WORD_BITS-1:0] w);
    logic [2:0] hb [8];
    logic [2:0] tb;
    tb = '0;
    for (int b = 0; b < 8; b++) begin
      hb[b] = '0;
      for (int i = 0; i < 8; i++) begin
        if (w[b*8+i]) hb[b] = 3'(i);
      end
      if (|w[b*8+:8]) tb = 3'(b);
    end
    return {tb, hb[tb]};
  endfunction

  function automatic logic [BIT_W-1:0] low64(input logic [WORD_BITS-1:0] w);
    logic [2:0] lb [8];
    logic [2:0] byte_sel;
    byte_sel = '0;
    for (int b = 7; b >= 0; b--) begin
      lb[b] = '0;
      for (int i = 7; i >= 0; i--) begin
        if (w[b*8+i]) lb[b] = 3'(i);
      end
      if (|w[b*8+:8]) byte_sel = 3'(b);
    end
    return {byte_sel, lb[byte_sel]};
  endfunction

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_vld_q;

  state_e               state_q, state_d;
  cmd_t                 cmd_q;
  logic [WORD_BITS-1:0] scan_q, scan_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [ELEM_W-1:0]    highest_q, highest_d;
  res_t                 res_q, res_d;
  logic                 out_valid_q;

  logic                 out_free, load_res, wr_en, in_range;
  logic [WORD_BITS-1:0] word, scan_rest;
  logic [BIT_W-1:0]     low_bit;
  logic [ELEM_W-1:0]    top_elem;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && q_valid_i;
  assign in_range    = (32'(cmd_q.addr) < MAP_WORDS);
  assign word        = (rd_vld_q && in_range) ? rd_q : '0;
  assign low_bit     = low64(scan_q);
  assign scan_rest   = scan_q & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << low_bit);
  assign top_elem    = {cmd_q.addr, top64(cmd_q.value)};
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    count_d   = count_q;
    highest_d = highest_q;
    load_res  = 1'b0;
    wr_en     = 1'b0;
    res_d     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (cmd_q.op)
            OP_INSERT, OP_MERGE: begin
              if (in_range && (cmd_q.value != '0)) begin
                wr_en   = 1'b1;
                count_d = count_q + COUNT_W'(ones64(cmd_q.value & ~word));
                if (top_elem > highest_q) highest_d = top_elem;
              end
              load_res   = 1'b1;
              res_d.last = 1'b1;
              state_d    = S_IDLE;
            end
            OP_QUERY: begin
              load_res    = 1'b1;
              res_d.found = word[cmd_q.sel];
              res_d.last  = 1'b1;
              state_d     = S_IDLE;
            end
            OP_LIST: begin
              if (word == '0) begin
                load_res   = 1'b1;
                res_d.last = 1'b1;
                state_d    = S_IDLE;
              end else begin
                scan_d  = word;
                state_d = S_LIST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          load_res           = 1'b1;
          res_d.member       = {cmd_q.addr, low_bit};
          res_d.member_valid = 1'b1;
          res_d.last         = (scan_rest == '0);
          scan_d             = scan_rest;
          if (scan_rest == '0) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res_d.member_count   = count_d;
    res_d.highest_member = highest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      highest_q   <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      highest_q <= highest_d;
      if (wr_en) vld_q[cmd_q.addr] <= 1'b1;
      if (pop_o) rd_vld_q <= vld_q[q_cmd_i.addr];
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cmd_q.addr] <= word | cmd_q.value;
    if (pop_o) rd_q <= mem[q_cmd_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= q_cmd_i;
    scan_q <= scan_d;
    if (load_res) res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> design/bmt_checker.sv
// Port-level checks for the bitset membership table, attached to the top
// level by a bind statement. Depends on bmt_pkg.
`default_nettype none

module bmt_checker import bmt_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic                 found_o,
  input wire logic [ELEM_W-1:0]    member_o,
  input wire logic                 member_valid_o,
  input wire logic                 last_o,
  input wire logic [COUNT_W-1:0]   member_count_o,
  input wire logic [ELEM_W-1:0]    highest_member_o
);

  logic              out_xfer;
  logic [COUNT_W-1:0] prev_count_q;
  logic              in_list_q;
  logic [ELEM_W-1:0] prev_member_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q  <= '0;
      in_list_q     <= 1'b0;
      prev_member_q <= '0;
    end else if (out_xfer) begin
      prev_count_q  <= member_count_o;
      in_list_q     <= member_valid_o && !last_o;
      prev_member_q <= member_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(member_o) &&
      $stable(last_o) && $stable(member_count_o))
    else $error("Stalled result changed.");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> member_count_o >= prev_count_q)
    else $error("Member count decreased between transfers.");

  a_list_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_list_q |-> member_valid_o && !found_o && member_o > prev_member_q)
    else $error("Listed members are not in ascending order.");

  a_member_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && member_valid_o |-> member_o <= highest_member_o && member_count_o != '0)
    else $error("Listed member exceeds the highest member.");

endmodule

bind bitset_membership_table_unit bmt_checker u_bmt_checker (.*);

`default_nettype wire

>>> bench/tb_bitset_membership_table_unit.sv
// Testbench for bitset_membership_table_unit: a queue-fed driver, a monitor and
// a shadow copy of the membership map that predicts every result transfer.
// Depends on bmt_pkg and the bitset_membership_table_unit RTL.

module tb_bitset_membership_table_unit;
  import bmt_pkg::*;

  typedef struct {
    op_e                  op;
    logic [ELEM_W-1:0]    element;
    logic [ADDR_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_value;
  } bmt_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode = OP_INSERT;
  logic [ELEM_W-1:0]    element = '0;
  logic [ADDR_W-1:0]    word_index = '0;
  logic [WORD_BITS-1:0] word_value = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic                 found_o;
  logic [ELEM_W-1:0]    member_o;
  logic                 member_valid_o;
  logic                 last_o;
  logic [COUNT_W-1:0]   member_count_o;
  logic [ELEM_W-1:0]    highest_member_o;

  bmt_item_t stim_q[$];
  res_t      pending_results[$];

  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [COUNT_W-1:0]   shadow_count = '0;
  logic [ELEM_W-1:0]    shadow_highest = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  bitset_membership_table_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode),
    .element_i        (element),
    .word_index_i     (word_index),
    .word_value_i     (word_value),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .found_o          (found_o),
    .member_o         (member_o),
    .member_valid_o   (member_valid_o),
    .last_o           (last_o),
    .member_count_o   (member_count_o),
    .highest_member_o (highest_member_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [12:0] got,
                             input logic [12:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic void queue_item(bmt_item_t it);
    stim_q.insert(stim_q.size(), it);
  endfunction

  function automatic void or_into_map(logic [ADDR_W-1:0] widx, logic [WORD_BITS-1:0] bits);
    logic [WORD_BITS-1:0] added;
    logic [ELEM_W-1:0]    top;
    if (bits == '0) return;
    added = bits & ~shadow_map[widx];
    shadow_map[widx] = shadow_map[widx] | bits;
    shadow_count = shadow_count + COUNT_W'($countones(added));
    top = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (bits[i]) top = {widx, 6'(i)};
    end
    if (top > shadow_highest) shadow_highest = top;
  endfunction

  function automatic void predict_transfer(bmt_item_t it);
    res_t                 r;
    logic [WORD_BITS-1:0] w;
    r = '0;
    r.last = 1'b1;
    case (it.op)
      OP_INSERT: or_into_map(it.element[11:6], 64'd1 << it.element[5:0]);
      OP_QUERY:  r.found = shadow_map[it.element[11:6]][it.element[5:0]];
      OP_MERGE:  or_into_map(it.word_index, it.word_value);
      default: begin
        w = shadow_map[it.word_index];
        if (w != '0) begin
          for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
              r.member = {it.word_index, 6'(i)};
              r.member_valid = 1'b1;
              r.last = ((w >> (i + 1)) == '0);
              r.member_count = shadow_count;
              r.highest_member = shadow_highest;
              pending_results.insert(pending_results.size(), r);
            end
          end
          return;
        end
      end
    endcase
    r.member_count = shadow_count;
    r.highest_member = shadow_highest;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Driver: a new item is presented only when the previous one has transferred.
  always @(posedge clk_i or negedge rst_ni) begin
    bmt_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || !in_stall_o) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = stim_q.pop_front();
          in_valid <= 1'b1;
          opcode <= it.op;
          element <= it.element;
          word_index <= it.word_index;
          word_value <= it.word_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bmt_item_t it;
    res_t      got;
    res_t      want;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        it.op = op_e'(opcode);
        it.element = element;
        it.word_index = word_index;
        it.word_value = word_value;
        predict_transfer(it);
      end
      if (out_valid_o && !out_stall) begin
        got.found = found_o;
        got.member = member_o;
        got.member_valid = member_valid_o;
        got.last = last_o;
        got.member_count = member_count_o;
        got.highest_member = highest_member_o;
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = pending_results.pop_front();
          check_field("found", 13'(got.found), 13'(want.found));
          check_field("member", 13'(got.member), 13'(want.member));
          check_field("member_valid", 13'(got.member_valid), 13'(want.member_valid));
          check_field("last", 13'(got.last), 13'(want.last));
          check_field("member_count", got.member_count, want.member_count);
          check_field("highest_member", 13'(got.highest_member),
                      13'(want.highest_member));
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] pick_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return ADDR_W'($urandom_range(1, 4));
      default: return ADDR_W'($urandom_range(MAP_WORDS - 1));
    endcase
  endfunction

  function automatic bmt_item_t rand_item();
    bmt_item_t it;
    int        pick;
    it.element = ELEM_W'($urandom_range(4095));
    it.word_index = ADDR_W'($urandom_range(MAP_WORDS - 1));
    it.word_value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.op = OP_INSERT;
      it.element = {pick_word(), 6'($urandom_range(63))};
    end else if (pick < 55) begin
      it.op = OP_QUERY;
      it.element = {pick_word(), 6'($urandom_range(63))};
    end else if (pick < 70) begin
      it.op = OP_MERGE;
      it.word_index = pick_word();
      case ($urandom_range(4))
        0:       it.word_value = 64'd1 << $urandom_range(63);
        1:       it.word_value = '1;
        2:       it.word_value = '0;
        3:       it.word_value = {$urandom, $urandom} & {$urandom, $urandom};
        default: it.word_value = {$urandom, $urandom};
      endcase
    end else begin
      it.op = OP_LIST;
      it.word_index = pick_word();
    end
    return it;
  endfunction

  function automatic bmt_item_t make_item(op_e op, int elem, int widx, logic [63:0] wval);
    bmt_item_t it;
    it.op = op;
    it.element = ELEM_W'(elem);
    it.word_index = ADDR_W'(widx);
    it.word_value = wval;
    return it;
  endfunction

  // Returns once every queued item has transferred and every result has arrived.
  task automatic drain();
    while (stim_q.size() > 0 || in_valid || pending_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) queue_item(rand_item());
    drain();
  endtask

  initial begin
    int order[MAP_WORDS];
    int j;
    int t;
    for (int i = 0; i < MAP_WORDS; i++) shadow_map[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty map, duplicate insert, the element extremes, full and sparse merges.
    queue_item(make_item(OP_LIST, 0, 0, '0));
    queue_item(make_item(OP_QUERY, 0, 0, '0));
    queue_item(make_item(OP_INSERT, 0, 0, '0));
    queue_item(make_item(OP_INSERT, 0, 0, '0));
    queue_item(make_item(OP_QUERY, 0, 0, '0));
    queue_item(make_item(OP_INSERT, 4095, 63, '1));
    queue_item(make_item(OP_QUERY, 4095, 0, '0));
    queue_item(make_item(OP_QUERY, 4094, 0, '0));
    queue_item(make_item(OP_LIST, 0, 63, '0));
    queue_item(make_item(OP_MERGE, 0, 5, '0));
    queue_item(make_item(OP_MERGE, 0, 1, '1));
    queue_item(make_item(OP_MERGE, 0, 1, '1));
    queue_item(make_item(OP_LIST, 0, 1, '0));
    queue_item(make_item(OP_MERGE, 0, 2, 64'h8000_0000_0000_0001));
    queue_item(make_item(OP_LIST, 0, 2, '0));
    queue_item(make_item(OP_INSERT, 130, 0, '0));
    queue_item(make_item(OP_MERGE, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA));
    queue_item(make_item(OP_LIST, 0, 0, '0));
    queue_item(make_item(OP_QUERY, 64, 0, '0));
    queue_item(make_item(OP_LIST, 0, 3, '0));
    queue_item(make_item(OP_MERGE, 0, 62, 64'h5555_5555_5555_5555));
    queue_item(make_item(OP_LIST, 0, 62, '0));
    drain();

    run_random(65, 0, 0);
    run_random(65, 81, 0);
    run_random(65, 0, 81);
    run_random(40, 10, 10);

    // Fill every word in shuffled order so the count reaches full capacity.
    for (int i = 0; i < MAP_WORDS; i++) order[i] = i;
    for (int i = MAP_WORDS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < MAP_WORDS; i++) begin
      queue_item(make_item(OP_MERGE, 0, order[i], '1));
    end
    repeat (10) queue_item(rand_item());
    queue_item(make_item(OP_LIST, 0, 63, '0));
    drain();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
